// ----- design/rgbed_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbed_pkg: shared types and constants of the RGB565 3x3 edge detector
// Register indexes, reset values, gray weights and the filter control bundle.
// ----------------------------------------------------------------------------
package rgbed_pkg;

	// default line store depth (pixels per line)
	localparam int MAX_WIDTH_DEF = 1024;

	// configuration port
	localparam int CFG_DW = 12;
	localparam int CFG_IW = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_HIGH   = 2'd2,
		REG_LOW    = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [10:0] WIDTH_RST  = 11'd640;
	localparam logic [11:0] HEIGHT_RST = 12'd480;
	localparam logic [11:0] HIGH_RST   = 12'd200;
	localparam logic [11:0] LOW_RST    = 12'd100;

	// geometry clamps
	localparam int MIN_DIM    = 3;
	localparam int MAX_HEIGHT = 4095;

	// beat kinds carried on tuser
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// gray conversion weights and rounding
	localparam logic [15:0] GW_RED   = 16'd76;
	localparam logic [15:0] GW_GREEN = 16'd150;
	localparam logic [15:0] GW_BLUE  = 16'd29;
	localparam logic [15:0] GRAY_RND = 16'd128;

	// edge strength saturation value
	localparam logic [11:0] EDGE_FULL = 12'd255;

	// control from the top level to the window filter
	typedef struct packed {
		logic adv;    // pipeline moves this cycle
		logic shift;  // stage 1 holds a pixel: window shifts
	} filt_ctl_t;

	// pack a gray byte (low three bits dropped) back into a 16-bit pixel
	function automatic logic [15:0] pack_gray(input logic [7:0] e);
		logic [7:0] q;
		q = {e[7:3], 3'b000};
		return {q, 8'h00} | {5'b00000, q, 3'b000} | {10'b0, q[7:2]};
	endfunction

endpackage
`default_nettype wire

// ----- design/rgbed_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgbed_filter: 3x3 window and edge kernels
// Holds the two older window columns, applies both kernels to the window
// formed with the incoming column, registers the absolute values, then sums,
// thresholds and packs the strength.
// ----------------------------------------------------------------------------
module rgbed_filter (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rgbed_pkg::filt_ctl_t  ctl,
	input  wire logic [7:0]            top,       // oldest line, current column
	input  wire logic [7:0]            mid,       // middle line, current column
	input  wire logic [7:0]            cur,       // current pixel gray
	input  wire logic [11:0]           high_thr,
	input  wire logic [11:0]           low_thr,
	output logic      [15:0]           edge_px
);

	// window columns: [0..2] oldest column rows 0..2, [3..5] middle column
	logic [7:0]  win_q [6];
	logic [11:0] ka;
	logic [12:0] kb;
	logic [9:0]  abs_a;
	logic [11:0] abs_b;
	logic [9:0]  abs_a_s2;
	logic [11:0] abs_b_s2;
	logic [11:0] strength;
	logic [11:0] limited;

	// window shift on each pixel beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= 8'd0;
		end else if (ctl.adv && ctl.shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= cur;
		end
	end

	// kernels in two's complement: A = cross Laplacian, B = mixed kernel
	always_comb begin
		ka = {2'b00, win_q[4], 2'b00} - 12'(win_q[3]) - 12'(win_q[1])
			- 12'(mid) - 12'(win_q[5]);
		kb = 13'(win_q[0]) + 13'(win_q[3]) + 13'(top) + {2'b00, win_q[4], 3'b000}
			- 13'(win_q[1]) - 13'(mid) - 13'(win_q[2]) - 13'(win_q[5])
			- 13'(cur);
		abs_a = ka[11] ? 10'(12'd0 - ka) : ka[9:0];
		abs_b = kb[12] ? 12'(13'd0 - kb) : kb[11:0];
	end

	// stage 2 registers
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			abs_a_s2 <= abs_a;
			abs_b_s2 <= abs_b;
		end
	end

	// dual threshold and pack
	always_comb begin
		strength = {2'b00, abs_a_s2} + abs_b_s2;
		if (strength > high_thr)
			limited = rgbed_pkg::EDGE_FULL;
		else if (strength < low_thr)
			limited = 12'd0;
		else
			limited = strength;
		edge_px = rgbed_pkg::pack_gray(limited[7:0]);
	end

`ifndef SYNTHESIS
	// the strength of two absolute kernel values never wraps
	// (windows over never-written line store entries carry unknown bits)
	a_strength_range: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(strength) |-> strength <= 12'd3825)
		else $error("edge strength out of range");

	// a stalled pipeline leaves the window untouched
	a_window_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.adv |=> $stable(win_q[4]) && $stable(win_q[1]))
		else $error("window moved while stalled");
`endif

endmodule
`default_nettype wire

// ----- design/rgb565_edge_detect_3x3_unit.sv -----
`default_nettype none
// Pipeline: an accepted beat passes stage 1 (line store read), the stage 2 kernel
//   registers and the output register to the master side; in stream order the
//   result lags its source pixel by one line plus one pixel.
// Throughput: one beat per clock; the line store reads one entry and writes one
//   entry each cycle, and the whole pipeline stalls only while a result waits.
// Reset: arst_n clears counters, window and valid bits; the line store is not
//   cleared, entries are written before any border-free output reads them.
// ----------------------------------------------------------------------------
// rgb565_edge_detect_3x3_unit: streaming 3x3 edge detector on RGB565 pixels
// Converts to gray, keeps two lines in a line store, filters a 3x3 window
// with two kernels and a dual threshold, and packs the result back to 16 bits.
// ----------------------------------------------------------------------------
module rgb565_edge_detect_3x3_unit #(
	parameter int MAX_WIDTH = rgbed_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [15:0]                   s_axis_tdata,  // [15:0] pixel_in
	input  wire logic                          s_axis_tuser,  // [0] action
	// output stream
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [15:0]                   m_axis_tdata,  // [15:0] pixel_out
	output logic                               m_axis_tlast,  // frame_end
	// configuration writes
	input  wire logic                          cfg_we,
	input  wire logic [rgbed_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [rgbed_pkg::CFG_DW-1:0]  cfg_wdata
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);

	// configuration registers
	logic [10:0] width_q;
	logic [11:0] height_q;
	logic [11:0] high_q;
	logic [11:0] low_q;
	logic        geom_wr;

	// position and pending state
	logic [AW-1:0] col_q;
	logic [11:0]   row_q;
	logic [PW-1:0] pend_q;

	// effective geometry
	logic [WW-1:0] w_eff;
	logic [11:0]   h_eff;
	logic [PW-1:0] wp1;

	// handshake
	logic adv;
	logic accept;
	logic is_flush;

	// stage 0 decisions
	logic          emit_s0;
	logic          inner_s0;
	logic          fend_s0;
	logic [PW-1:0] pend_d;
	logic [PW-1:0] pend_next;
	logic          last_col;
	logic [15:0]   gray_sum;

	// stage 1
	logic          v_s1;
	logic          pix_s1;
	logic          emit_s1;
	logic          inner_s1;
	logic          fend_s1;
	logic [7:0]    gray_s1;
	logic [AW-1:0] col_s1;
	logic [15:0]   rd_s1;   // [7:0] oldest line, [15:8] middle line

	// stage 2
	logic          v_s2;
	logic          inner_s2;
	logic          fend_s2;
	logic [15:0]   edge_px;

	// output register
	logic          out_v_q;
	logic [15:0]   out_px_q;
	logic          out_last_q;

	// line store: one word per column holding both previous lines
	logic [15:0] line_mem [MAX_WIDTH];

	rgbed_pkg::filt_ctl_t fctl;

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgbed_pkg::WIDTH_RST;
			height_q <= rgbed_pkg::HEIGHT_RST;
			high_q   <= rgbed_pkg::HIGH_RST;
			low_q    <= rgbed_pkg::LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbed_pkg::REG_WIDTH:  width_q  <= cfg_wdata[10:0];
				rgbed_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				rgbed_pkg::REG_HIGH:   high_q   <= cfg_wdata;
				rgbed_pkg::REG_LOW:    low_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign geom_wr = cfg_we && (cfg_index == rgbed_pkg::REG_WIDTH ||
		cfg_index == rgbed_pkg::REG_HEIGHT);

	// clamp geometry
	always_comb begin
		if (32'(width_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else if (32'(width_q) < rgbed_pkg::MIN_DIM)
			w_eff = WW'(rgbed_pkg::MIN_DIM);
		else
			w_eff = WW'(width_q);
		if (32'(height_q) < rgbed_pkg::MIN_DIM)
			h_eff = 12'(rgbed_pkg::MIN_DIM);
		else
			h_eff = height_q;
		wp1 = PW'(w_eff) + PW'(1);
	end

	// handshake: everything moves unless a result waits
	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign is_flush      = (s_axis_tuser == rgbed_pkg::ACT_FLUSH);

	// gray conversion
	always_comb begin
		gray_sum = 16'({s_axis_tdata[15:11], 3'b000}) * rgbed_pkg::GW_RED
			+ 16'({s_axis_tdata[5:0], 2'b00}) * rgbed_pkg::GW_GREEN
			+ 16'({s_axis_tdata[10:6], 3'b000}) * rgbed_pkg::GW_BLUE
			+ rgbed_pkg::GRAY_RND;
	end

	// stage 0: emit decision, output position class, pending count
	always_comb begin
		last_col  = (WW'(col_q) == w_eff - WW'(1));
		pend_d    = (pend_q > wp1) ? wp1 : pend_q;
		emit_s0   = 1'b0;
		inner_s0  = 1'b0;
		fend_s0   = 1'b0;
		pend_next = pend_q;
		if (is_flush) begin
			// drain only at a frame start with something owed
			if (col_q == '0 && row_q == '0 && pend_q != '0) begin
				emit_s0   = 1'b1;
				fend_s0   = (pend_d == PW'(1));
				pend_next = pend_d - PW'(1);
			end
		end else if (pend_q >= wp1) begin
			emit_s0   = 1'b1;
			// output sits one line and one pixel back
			inner_s0  = (col_q >= AW'(2)) && (row_q >= 12'd2);
			fend_s0   = (col_q == '0) && (row_q == 12'd1);
			pend_next = wp1;
		end else begin
			pend_next = pend_q + PW'(1);
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (geom_wr) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			pend_q <= pend_next;
			if (!is_flush) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= (row_q == h_eff - 12'd1) ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// line store read at acceptance, write back from stage 1
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= line_mem[col_q];
		if (adv && v_s1 && pix_s1)
			line_mem[col_s1] <= {gray_s1, rd_s1[15:8]};
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1   <= !is_flush;
			emit_s1  <= emit_s0;
			inner_s1 <= inner_s0;
			fend_s1  <= fend_s0;
			gray_s1  <= gray_sum[15:8];
			col_s1   <= col_q;
		end
	end

	// window and kernels
	assign fctl.adv   = adv;
	assign fctl.shift = v_s1 && pix_s1;

	rgbed_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fctl),
		.top      (rd_s1[7:0]),
		.mid      (rd_s1[15:8]),
		.cur      (gray_s1),
		.high_thr (high_q),
		.low_thr  (low_q),
		.edge_px  (edge_px)
	);

	// stage 2 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inner_s2 <= inner_s1;
			fend_s2  <= fend_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_px_q   <= inner_s2 ? edge_px : 16'd0;
			out_last_q <= fend_s2;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_px_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// owed outputs never exceed one line plus one pixel
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= wp1)
		else $error("pending count above line plus one");

	// column stays inside the active line
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < w_eff)
		else $error("column counter past line end");

	// read and write-back of the line store never hit the same entry together
	a_mem_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && v_s1 && pix_s1) |-> (col_s1 != col_q))
		else $error("line store read and write collide");

	// the last pixel of a frame is a border pixel
	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == 16'd0))
		else $error("frame end carries nonzero pixel");

	// input is held back only by a waiting result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");
`endif

endmodule
`default_nettype wire
